### src/ppf_pkg.sv
package ppf_pkg;

    // Width of the signed input value
    localparam int VALUE_WIDTH = 32;
    // Magnitude bits of a positive value
    localparam int MAG_W = VALUE_WIDTH - 1;
    // Base counter width: holds floor(sqrt(max value)) + 1
    localparam int M_W = (VALUE_WIDTH + 1) / 2;
    // Divider bit counter width
    localparam int CNT_W = $clog2(MAG_W);
    // Division count per base, holds up to MAG_W
    localparam int K_W = $clog2(MAG_W + 1);

    // Result field widths
    localparam int BASE_W = 16;
    localparam int EXP_W = 5;
    localparam int STATUS_W = 2;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_FOUND        = 2'd0,
        STATUS_NOT_POWER    = 2'd1,
        STATUS_NOT_POSITIVE = 2'd2
    } status_t;

    // Request to the shared divider
    typedef struct packed {
        logic             start;
        logic [MAG_W-1:0] dividend;
        logic [M_W-1:0]   divisor;
    } div_req_t;

    // Response from the shared divider
    typedef struct packed {
        logic             done;
        logic [MAG_W-1:0] quotient;
        logic [M_W-1:0]   remainder;
    } div_rsp_t;

    // Finished result handed from the sequencer to the output stage
    typedef struct packed {
        logic              valid;
        logic [BASE_W-1:0] base;
        logic [EXP_W-1:0]  exponent;
        status_t           status;
    } ppf_result_t;

endpackage

### src/ppf_div.sv
// Restoring divider, one quotient bit per cycle.
module ppf_div
    import ppf_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  div_req_t req,
    output div_rsp_t rsp
);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [MAG_W-1:0] quo_reg, quo_next;
    logic [M_W-1:0]   rem_reg, rem_next;
    logic [M_W-1:0]   dsr_reg, dsr_next;

    logic [M_W:0]     trial;
    logic [M_W+1:0]   diff;
    logic             fits;

    // Trial subtract of the divisor from the shifted partial remainder
    always_comb
    begin
        trial = {rem_reg, quo_reg[MAG_W-1]};
        diff  = {1'b0, trial} - {2'b00, dsr_reg};
        fits  = ~diff[M_W+1];
    end

    // Step the division or load a new one
    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(MAG_W - 1);
            quo_next  = req.dividend;
            rem_next  = '0;
            dsr_next  = req.divisor;
        end
        else if (busy_reg)
        begin
            quo_next = {quo_reg[MAG_W-2:0], fits};
            rem_next = fits ? diff[M_W-1:0] : trial[M_W-1:0];
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else
            begin
                cnt_next = cnt_reg - 1'b1;
            end
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
    end

    assign rsp.done      = done_reg;
    assign rsp.quotient  = quo_reg;
    assign rsp.remainder = rem_reg;

endmodule

### src/ppf_ctrl.sv
// Search sequencer: walks the bases and repeated divisions on the shared divider.
//   Divide the current quotient by base m. On the first division of a base a
//   quotient below m ends the search (m is past the square root). A nonzero
//   remainder or a quotient below m moves to the next base. A quotient equal
//   to m is a hit with exponent one more than the divisions done.
module ppf_ctrl
    import ppf_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    input  logic [VALUE_WIDTH-1:0] value,
    input  logic                   take,
    output logic                   idle,
    output ppf_result_t            res
);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_RUN  = 3'b010,
        ST_HOLD = 3'b100
    } state_t;

    state_t            state_reg, state_next;
    logic [MAG_W-1:0]  v_reg, v_next;
    logic [M_W-1:0]    m_reg, m_next;
    logic [K_W-1:0]    k_reg, k_next;
    logic [BASE_W-1:0] base_reg, base_next;
    logic [EXP_W-1:0]  exp_reg, exp_next;
    status_t           status_reg, status_next;

    div_req_t          req;
    div_rsp_t          rsp;

    logic [M_W-1:0]    m_inc;
    logic [K_W-1:0]    k_inc;
    logic              q_lt_m;
    logic              q_eq_m;
    logic              first;

    ppf_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp)
    );

    // Compare the quotient against the current base
    always_comb
    begin
        m_inc  = m_reg + 1'b1;
        k_inc  = k_reg + 1'b1;
        q_lt_m = rsp.quotient < MAG_W'(m_reg);
        q_eq_m = rsp.quotient == MAG_W'(m_reg);
        first  = k_reg == K_W'(1);
    end

    // Sequence the search
    always_comb
    begin
        state_next   = state_reg;
        v_next       = v_reg;
        m_next       = m_reg;
        k_next       = k_reg;
        base_next    = base_reg;
        exp_next     = exp_reg;
        status_next  = status_reg;
        req.start    = 1'b0;
        req.dividend = v_reg;
        req.divisor  = m_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    base_next = '0;
                    exp_next  = '0;
                    if (value[VALUE_WIDTH-1] || (value == '0))
                    begin
                        status_next = STATUS_NOT_POSITIVE;
                        state_next  = ST_HOLD;
                    end
                    else
                    begin
                        v_next       = value[MAG_W-1:0];
                        m_next       = M_W'(2);
                        k_next       = K_W'(1);
                        req.start    = 1'b1;
                        req.dividend = value[MAG_W-1:0];
                        req.divisor  = M_W'(2);
                        state_next   = ST_RUN;
                    end
                end
            end
            ST_RUN:
            begin
                if (rsp.done)
                begin
                    if (first && q_lt_m)
                    begin
                        // Base passed the square root: give up
                        status_next = STATUS_NOT_POWER;
                        state_next  = ST_HOLD;
                    end
                    else if ((rsp.remainder != '0) || q_lt_m)
                    begin
                        // Advance to the next base
                        m_next       = m_inc;
                        k_next       = K_W'(1);
                        req.start    = 1'b1;
                        req.dividend = v_reg;
                        req.divisor  = m_inc;
                    end
                    else if (q_eq_m)
                    begin
                        base_next   = BASE_W'(m_reg);
                        exp_next    = EXP_W'(k_inc);
                        status_next = STATUS_FOUND;
                        state_next  = ST_HOLD;
                    end
                    else
                    begin
                        // Divide the quotient again by the same base
                        k_next       = k_inc;
                        req.start    = 1'b1;
                        req.dividend = rsp.quotient;
                        req.divisor  = m_reg;
                    end
                end
            end
            ST_HOLD:
            begin
                if (take)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Search and result registers
    always_ff @(posedge clk)
    begin
        v_reg      <= v_next;
        m_reg      <= m_next;
        k_reg      <= k_next;
        base_reg   <= base_next;
        exp_reg    <= exp_next;
        status_reg <= status_next;
    end

    assign idle         = state_reg == ST_IDLE;
    assign res.valid    = state_reg == ST_HOLD;
    assign res.base     = base_reg;
    assign res.exponent = exp_reg;
    assign res.status   = status_reg;

endmodule

### src/perfect_power_finder.sv
// Channel | Signals                            | Transfer when
// --------+------------------------------------+---------------------------
// in      | in_valid, in_ready, value          | in_valid && in_ready
// out     | out_valid, out_ready, base,        | out_valid && out_ready
//         | exponent, status                   |
//
// Each trial division runs on the shared restoring divider (one quotient
// bit per cycle); an item takes one division per base plus one per extra
// power, the most for a prime near 2^31. A zero or negative value skips the
// divider. A new value is taken once the finished result has moved into the
// output register, even while that register still holds it. Reset (rst_n,
// async) clears the sequencer and the output valid flag.
module perfect_power_finder
    import ppf_pkg::*;
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic signed [VALUE_WIDTH-1:0] value,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [BASE_W-1:0]             base,
    output logic [EXP_W-1:0]              exponent,
    output logic [STATUS_W-1:0]           status
);

    ppf_result_t       res;
    logic              idle;
    logic              take;
    logic              out_valid_reg, out_valid_next;
    logic [BASE_W-1:0] base_reg;
    logic [EXP_W-1:0]  exp_reg;
    status_t           status_reg;

    ppf_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (in_valid && idle),
        .value (value),
        .take  (take),
        .idle  (idle),
        .res   (res)
    );

    // Move a finished result into the output register when it is free
    always_comb
    begin
        take = res.valid && (!out_valid_reg || out_ready);
        if (take)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    // Output valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    // Output payload, hold until the transfer
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            base_reg   <= res.base;
            exp_reg    <= res.exponent;
            status_reg <= res.status;
        end
    end

    assign in_ready  = idle;
    assign out_valid = out_valid_reg;
    assign base      = base_reg;
    assign exponent  = exp_reg;
    assign status    = status_reg;

endmodule

### src/ppf_checker.sv
module ppf_checker
    import ppf_pkg::*;
(
    input logic                          clk,
    input logic                          rst_n,
    input logic                          in_valid,
    input logic                          in_ready,
    input logic                          out_valid,
    input logic                          out_ready,
    input logic [BASE_W-1:0]             base,
    input logic [EXP_W-1:0]              exponent,
    input logic [STATUS_W-1:0]           status
);

    // Block is busy right after taking a value
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
    else $error("in_ready high the cycle after an input transfer");

    // Stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(base) && $stable(exponent)
            && $stable(status))
    else $error("stalled result changed");

    // A hit has base and exponent of at least two
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == STATUS_FOUND) |-> (base >= BASE_W'(2))
            && (exponent >= EXP_W'(2)))
    else $error("found result with base or exponent below two");

    // A miss reports zero base and exponent with a known code
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status != STATUS_FOUND) |-> (base == '0) && (exponent == '0)
            && ((status == STATUS_NOT_POWER) || (status == STATUS_NOT_POSITIVE)))
    else $error("miss result with nonzero fields or bad status");

endmodule

bind perfect_power_finder ppf_checker u_ppf_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .base      (base),
    .exponent  (exponent),
    .status    (status)
);

### sim/tb.sv
`timescale 1ns / 100ps

module tb;
    import ppf_pkg::*;

    // One expected result, at the widths of the output ports
    typedef struct packed {
        logic [BASE_W-1:0] base;
        logic [EXP_W-1:0]  exponent;
        status_t           status;
    } power_result_t;

    logic                          clk;
    logic                          rst_n;
    logic                          in_valid = 1'b0;
    logic                          in_ready;
    logic signed [VALUE_WIDTH-1:0] value = '0;
    logic                          out_valid;
    logic                          out_ready = 1'b0;
    logic [BASE_W-1:0]             base;
    logic [EXP_W-1:0]              exponent;
    logic [STATUS_W-1:0]           status;

    logic signed [VALUE_WIDTH-1:0] pending_values[$];
    power_result_t                 expected_results[$];
    int                            send_gap = 0;
    int                            recv_gap = 0;
    int                            hold_left = 0;
    int                            errors = 0;

    perfect_power_finder dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .value     (value),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .base      (base),
        .exponent  (exponent),
        .status    (status)
    );

    always
    begin
        clk = 1'b1;
        #4;
        clk = 1'b0;
        #4;
    end

    // Smallest base m >= 2 with m^n == v for some n >= 2, searched upward
    function automatic power_result_t find_power(logic signed [VALUE_WIDTH-1:0] v);
        power_result_t    r;
        longint unsigned  mag;
        longint unsigned  m;
        longint unsigned  num;
        int unsigned      n;
        bit               found;
        bit               stop;
        r.base = '0;
        r.exponent = '0;
        r.status = STATUS_NOT_POWER;
        if (v <= 0)
        begin
            r.status = STATUS_NOT_POSITIVE;
            return r;
        end
        mag = {{(64 - VALUE_WIDTH){1'b0}}, v};
        found = 1'b0;
        for (m = 2; m * m <= mag && !found; m++)
        begin
            num = m;
            n = 2;
            stop = 1'b0;
            // Climb the powers of m while they divide the value
            while (!stop && !found && (mag % num) == 0)
            begin
                if (num > mag / m)
                    stop = 1'b1;
                else
                begin
                    num = num * m;
                    if (num == mag)
                    begin
                        r.base = BASE_W'(m);
                        r.exponent = EXP_W'(n);
                        r.status = STATUS_FOUND;
                        found = 1'b1;
                    end
                    else
                        n++;
                end
            end
        end
        return r;
    endfunction

    // Sender: offer queued values, record the expected result on each transfer
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            value <= '0;
            send_gap <= 0;
        end
        else
        begin
            if (in_valid && in_ready)
                expected_results.push_back(find_power(value));
            if (in_valid && !in_ready)
            begin
                // hold the offer until it is taken
            end
            else if (send_gap > 0)
            begin
                send_gap <= send_gap - 1;
                in_valid <= 1'b0;
            end
            else if (pending_values.size() > 0 &&
                     (pending_values.size() < 12 || $urandom_range(0, 3) != 0))
            begin
                in_valid <= 1'b1;
                value <= pending_values.pop_front();
            end
            else
            begin
                in_valid <= 1'b0;
                if (pending_values.size() > 0)
                    send_gap <= $urandom_range(1, 16) - 1;
            end
        end
    end

    // Receiver: check each result transfer, stall in bursts
    always @(posedge clk or negedge rst_n)
    begin : receive_side
        power_result_t want;
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            recv_gap <= 0;
            // long hold-off right after reset so the block backs up
            hold_left <= 400;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (expected_results.size() == 0)
                begin
                    $display("%0t: result with nothing expected: base %0d exponent %0d status %0d",
                             $time, base, exponent, status);
                    errors++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (base !== want.base)
                    begin
                        $display("%0t: base mismatch: expected %0d, actual %0d",
                                 $time, want.base, base);
                        errors++;
                    end
                    if (exponent !== want.exponent)
                    begin
                        $display("%0t: exponent mismatch: expected %0d, actual %0d",
                                 $time, want.exponent, exponent);
                        errors++;
                    end
                    if (status !== want.status)
                    begin
                        $display("%0t: status mismatch: expected %0d, actual %0d",
                                 $time, want.status, status);
                        errors++;
                    end
                end
            end
            if (hold_left > 0)
            begin
                hold_left <= hold_left - 1;
                out_ready <= 1'b0;
            end
            else if (recv_gap > 0)
            begin
                recv_gap <= recv_gap - 1;
                out_ready <= 1'b0;
            end
            else if (pending_values.size() < 12 || $urandom_range(0, 3) != 0)
                out_ready <= 1'b1;
            else
            begin
                out_ready <= 1'b0;
                recv_gap <= $urandom_range(1, 16) - 1;
            end
        end
    end

    // Fill the stimulus queue, run, and report
    initial
    begin
        longint unsigned pw;
        int unsigned     b;
        int unsigned     emax;
        int unsigned     k;
        int unsigned     pick;
        rst_n = 1'b0;

        // Directed: fast items first so the early hold-off fills the block
        pending_values.push_back(32'sh8000_0000);
        pending_values.push_back(-1);
        pending_values.push_back(0);
        pending_values.push_back(1);
        pending_values.push_back(-32'sd1073741824);
        pending_values.push_back(2);
        pending_values.push_back(3);
        pending_values.push_back(4);
        pending_values.push_back(8);
        // next power would pass the value while the current one divides it
        pending_values.push_back(18);
        pending_values.push_back(12);
        // composite base reported through its smallest root
        pending_values.push_back(36);
        pending_values.push_back(64);
        pending_values.push_back(1296);
        pending_values.push_back(625);
        pending_values.push_back(17);
        pending_values.push_back(1000000);
        pending_values.push_back(32'sd1073741824);
        pending_values.push_back(32'sd1162261467);
        pending_values.push_back(32'sd1977326743);
        // largest value: full search over every base
        pending_values.push_back(32'sd2147483647);

        // Random mix kept to short searches
        repeat (100)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 25)
                pending_values.push_back($urandom | 32'h8000_0000);
            else if (pick < 55)
            begin
                // perfect power with random base and exponent
                b = ($urandom_range(0, 3) == 0) ? $urandom_range(41, 200)
                                                : $urandom_range(2, 40);
                pw = b;
                emax = 1;
                while (pw * b < 64'h8000_0000)
                begin
                    pw = pw * b;
                    emax++;
                end
                k = $urandom_range(2, emax);
                pw = 1;
                repeat (k)
                    pw = pw * b;
                pending_values.push_back(VALUE_WIDTH'(pw));
            end
            else if (pick < 85)
                pending_values.push_back($urandom_range(1, 4095));
            else
            begin
                // power of a small base times a smaller cofactor
                b = $urandom_range(3, 30);
                pw = b * b;
                while (pw * b * b < 65536 && $urandom_range(0, 1) == 1)
                    pw = pw * b;
                pw = pw * $urandom_range(1, b - 1);
                pending_values.push_back(VALUE_WIDTH'(pw));
            end
        end

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // Drain: wait for every item to go in and every result to come out
        while (pending_values.size() != 0 || in_valid || expected_results.size() != 0)
            @(posedge clk);
        repeat (64) @(posedge clk);
        if (errors == 0)
            $display("PASS perfect_power_finder");
        else
            $display("FAIL perfect_power_finder");
        $finish;
    end

    // Watchdog
    initial
    begin
        #100_000_000;
        $display("FAIL perfect_power_finder");
        $finish;
    end

endmodule
